[rtl/core/ntt_pkg.sv]
package ntt_pkg;

  // default geometry of the table
  localparam int unsigned DefTableDepth = 256;
  localparam int unsigned DefCountWidth = 16;

  // register file layout
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EVIDENCE_THRESHOLD = 2'd0,
    CFG_PRIOR_WEIGHT       = 2'd1
  } cfg_reg_t;

  localparam logic [15:0] THRESHOLD_RESET = 16'd10;
  localparam logic [7:0]  PRIOR_RESET     = 8'd1;

  // one trust report
  typedef struct packed {
    logic [7:0] node_id;
    logic [7:0] neg_increment;
    logic [7:0] pos_increment;
  } in_t;

  // one report outcome
  typedef struct packed {
    logic        was_known;
    logic        inserted;
    logic        table_full;
    logic [15:0] neg_total;
    logic [15:0] pos_total;
    logic        malicious;
  } out_t;

  // memory strobes from the controller to the entry store
  typedef struct packed {
    logic rd_en;
    logic id_we;
    logic tot_we;
  } mem_cmd_t;

endpackage

[rtl/core/ntt_store.sv]
module ntt_store #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned COUNT_WIDTH = 16,
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                   clk,
  input  ntt_pkg::mem_cmd_t      cmd,
  input  logic [IDX_W-1:0]       rd_addr,
  input  logic [IDX_W-1:0]       wr_addr,
  input  logic [7:0]             wr_id,
  input  logic [COUNT_WIDTH-1:0] wr_neg,
  input  logic [COUNT_WIDTH-1:0] wr_pos,
  output logic [7:0]             rd_id,
  output logic [COUNT_WIDTH-1:0] rd_neg,
  output logic [COUNT_WIDTH-1:0] rd_pos
);
  import ntt_pkg::*;

  logic [7:0]               id_mem  [TABLE_DEPTH];
  logic [2*COUNT_WIDTH-1:0] tot_mem [TABLE_DEPTH];
  logic [2*COUNT_WIDTH-1:0] tot_rd_r;

  // key memory
  always_ff @(posedge clk) begin
    if (cmd.id_we) begin
      id_mem[wr_addr] <= wr_id;
    end
    if (cmd.rd_en) begin
      rd_id <= id_mem[rd_addr];
    end
  end

  // totals memory, negative count in the upper half
  always_ff @(posedge clk) begin
    if (cmd.tot_we) begin
      tot_mem[wr_addr] <= {wr_neg, wr_pos};
    end
    if (cmd.rd_en) begin
      tot_rd_r <= tot_mem[rd_addr];
    end
  end

  assign rd_neg = tot_rd_r[2*COUNT_WIDTH-1:COUNT_WIDTH];
  assign rd_pos = tot_rd_r[COUNT_WIDTH-1:0];

endmodule

[rtl/core/ntt_ctrl.sv]
module ntt_ctrl #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned COUNT_WIDTH = 16,
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  ntt_pkg::in_t           in_data,
  output logic                   busy,
  output logic                   out_strobe,
  output ntt_pkg::out_t          out_data,
  input  logic [15:0]            threshold,
  input  logic [7:0]             prior,
  output ntt_pkg::mem_cmd_t      cmd,
  output logic [IDX_W-1:0]       rd_addr,
  output logic [IDX_W-1:0]       wr_addr,
  output logic [7:0]             wr_id,
  output logic [COUNT_WIDTH-1:0] wr_neg,
  output logic [COUNT_WIDTH-1:0] wr_pos,
  input  logic [7:0]             rd_id,
  input  logic [COUNT_WIDTH-1:0] rd_neg,
  input  logic [COUNT_WIDTH-1:0] rd_pos
);
  import ntt_pkg::*;

  localparam int unsigned SUM_W = (COUNT_WIDTH + 2 > 17) ? COUNT_WIDTH + 2 : 17;
  localparam int unsigned EXT_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_JUDGE  = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  in_t                    item_r, item_nxt;
  logic [CNT_W-1:0]       scan_r, scan_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]       cmp_idx_r, cmp_idx_nxt;
  logic [COUNT_WIDTH-1:0] neg_r, neg_nxt;
  logic [COUNT_WIDTH-1:0] pos_r, pos_nxt;
  out_t                   out_r, out_nxt;
  logic                   strobe_r, strobe_nxt;

  logic                   hit;
  logic                   scan_more;
  logic [COUNT_WIDTH:0]   sum_neg, sum_pos;
  logic [COUNT_WIDTH-1:0] sat_neg, sat_pos;
  logic [SUM_W-1:0]       evidence;
  logic                   mal;
  logic [EXT_W-1:0]       neg_ext, pos_ext;

  // compare stage of the scan and saturating update of a hit
  assign hit       = cmp_vld_r && (rd_id == item_r.node_id);
  assign scan_more = scan_r < count_r;
  assign sum_neg   = {1'b0, rd_neg} + (COUNT_WIDTH + 1)'(item_r.neg_increment);
  assign sum_pos   = {1'b0, rd_pos} + (COUNT_WIDTH + 1)'(item_r.pos_increment);
  assign sat_neg   = sum_neg[COUNT_WIDTH] ? '1 : sum_neg[COUNT_WIDTH-1:0];
  assign sat_pos   = sum_pos[COUNT_WIDTH] ? '1 : sum_pos[COUNT_WIDTH-1:0];

  // judgment on the updated totals
  assign evidence = SUM_W'(prior) + SUM_W'(neg_r) + SUM_W'(pos_r);
  assign mal      = (pos_r < neg_r) && (evidence > SUM_W'(threshold));
  assign neg_ext  = EXT_W'(neg_r);
  assign pos_ext  = EXT_W'(pos_r);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    item_nxt    = item_r;
    scan_nxt    = scan_r;
    count_nxt   = count_r;
    cmp_vld_nxt = 1'b0;
    cmp_idx_nxt = cmp_idx_r;
    neg_nxt     = neg_r;
    pos_nxt     = pos_r;
    out_nxt     = out_r;
    strobe_nxt  = 1'b0;
    cmd         = '0;
    rd_addr     = scan_r[IDX_W-1:0];
    wr_addr     = cmp_idx_r;
    wr_id       = item_r.node_id;
    wr_neg      = sat_neg;
    wr_pos      = sat_pos;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          item_nxt  = in_data;
          scan_nxt  = '0;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          // write the updated totals back, judge next cycle
          cmd.tot_we = 1'b1;
          neg_nxt    = sat_neg;
          pos_nxt    = sat_pos;
          state_nxt  = ST_JUDGE;
        end else if (!cmp_vld_r && !scan_more) begin
          // miss: insert at the fill count or drop
          out_nxt    = '0;
          strobe_nxt = 1'b1;
          state_nxt  = ST_IDLE;
          if (count_r < CNT_W'(TABLE_DEPTH)) begin
            cmd.id_we          = 1'b1;
            cmd.tot_we         = 1'b1;
            wr_addr            = count_r[IDX_W-1:0];
            wr_neg             = COUNT_WIDTH'(item_r.neg_increment);
            wr_pos             = COUNT_WIDTH'(item_r.pos_increment);
            count_nxt          = count_r + 1'b1;
            out_nxt.inserted   = 1'b1;
            out_nxt.neg_total  = 16'(item_r.neg_increment);
            out_nxt.pos_total  = 16'(item_r.pos_increment);
          end else begin
            out_nxt.table_full = 1'b1;
          end
        end else if (scan_more) begin
          // fetch the next stored entry
          cmd.rd_en   = 1'b1;
          scan_nxt    = scan_r + 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = scan_r[IDX_W-1:0];
        end
      end
      ST_JUDGE: begin
        out_nxt.was_known  = 1'b1;
        out_nxt.inserted   = 1'b0;
        out_nxt.table_full = 1'b0;
        out_nxt.neg_total  = neg_ext[15:0];
        out_nxt.pos_total  = pos_ext[15:0];
        out_nxt.malicious  = mal;
        strobe_nxt         = 1'b1;
        state_nxt          = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
      strobe_r  <= 1'b0;
      scan_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      strobe_r  <= strobe_nxt;
      scan_r    <= scan_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    neg_r     <= neg_nxt;
    pos_r     <= pos_nxt;
    out_r     <= out_nxt;
  end

  assign busy       = !state_r[0];
  assign out_strobe = strobe_r;
  assign out_data   = out_r;

endmodule

[rtl/core/node_trust_table.sv]
// node trust table
// in: start with in_data (node id, negative and positive increments) is taken
//   at a clock edge where busy is low; busy stays high until the result is out
// out: one transaction per report, out_data valid for exactly one cycle while
//   out_strobe is high; there is no backpressure, the receiver must take it
// cfg: cfg_we writes cfg_wdata into register cfg_index (0 evidence threshold,
//   1 prior weight, low bits used); unknown indexes are ignored
// timing: the stored ids are scanned one entry per cycle out of the key
//   memory until a hit or the end of the filled entries, and the outcome is
//   registered before the strobe; a new report may start in the strobe cycle
// reset: synchronous, active low; the entry count drops to zero and the
//   registers return to threshold 10 and prior 1; no memory clearing pass,
//   entries at or above the count are never read
module node_trust_table #(
  parameter int unsigned TABLE_DEPTH = ntt_pkg::DefTableDepth,
  parameter int unsigned COUNT_WIDTH = ntt_pkg::DefCountWidth
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  ntt_pkg::in_t                   in_data,
  output logic                           out_strobe,
  output ntt_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [ntt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ntt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ntt_pkg::*;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [15:0]            threshold_r;
  logic [7:0]             prior_r;
  mem_cmd_t               cmd;
  logic [IDX_W-1:0]       rd_addr, wr_addr;
  logic [7:0]             wr_id, rd_id;
  logic [COUNT_WIDTH-1:0] wr_neg, wr_pos, rd_neg, rd_pos;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
      prior_r     <= PRIOR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EVIDENCE_THRESHOLD: threshold_r <= cfg_wdata[15:0];
        CFG_PRIOR_WEIGHT:       prior_r     <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  ntt_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_data    (in_data),
    .busy       (busy),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .threshold  (threshold_r),
    .prior      (prior_r),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .wr_id      (wr_id),
    .wr_neg     (wr_neg),
    .wr_pos     (wr_pos),
    .rd_id      (rd_id),
    .rd_neg     (rd_neg),
    .rd_pos     (rd_pos)
  );

  ntt_store #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_store (
    .clk     (clk),
    .cmd     (cmd),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_id   (wr_id),
    .wr_neg  (wr_neg),
    .wr_pos  (wr_pos),
    .rd_id   (rd_id),
    .rd_neg  (rd_neg),
    .rd_pos  (rd_pos)
  );

  // a result only closes a transaction that was in flight
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without a transaction in flight");

  // an accepted report occupies the block
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted report did not raise busy");

  // exactly one outcome per report
  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $onehot({out_data.was_known, out_data.inserted, out_data.table_full}))
    else $error("result outcome flags not one-hot");

  // only known nodes are judged, dropped reports carry no totals
  a_flag_rules: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ((!out_data.malicious || out_data.was_known) &&
                    (!out_data.table_full ||
                     (out_data.neg_total == '0 && out_data.pos_total == '0))))
    else $error("malicious or dropped result fields inconsistent");

endmodule

[tb/node_trust_table_check.sv]
`timescale 1ns / 1ps

// watches the report, outcome and register ports, keeps its own copy of the
// trust table and compares every outcome transaction with the oldest prediction
module node_trust_table_check (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  ntt_pkg::in_t                   in_data,
  input  logic                           out_strobe,
  input  ntt_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [ntt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ntt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned                    fail_count,
  output int unsigned                    pending_reports
);
  import ntt_pkg::*;

  localparam int unsigned Depth = DefTableDepth;

  // shadow of the table and the trust rule
  logic [7:0]  entry_ids [Depth];
  logic [15:0] entry_neg [Depth];
  logic [15:0] entry_pos [Depth];
  int unsigned entries;
  logic [15:0] threshold;
  logic [7:0]  prior;

  out_t expected_outcomes [$];
  out_t oldest;

  // totals stop at the top of the count range
  function automatic logic [15:0] sat_add(input logic [15:0] total, input logic [7:0] step);
    logic [16:0] sum;
    sum = {1'b0, total} + {9'd0, step};
    return sum[16] ? 16'hFFFF : sum[15:0];
  endfunction

  // search, then update or insert, and work out the outcome
  function automatic out_t score_report(input in_t r);
    out_t        o;
    int          hit;
    logic [17:0] evidence;
    o   = '0;
    hit = -1;
    for (int unsigned k = 0; k < entries; k++) begin
      if (entry_ids[k] == r.node_id) begin
        hit = int'(k);
        break;
      end
    end
    if (hit >= 0) begin
      o.was_known      = 1'b1;
      o.neg_total      = sat_add(entry_neg[hit], r.neg_increment);
      o.pos_total      = sat_add(entry_pos[hit], r.pos_increment);
      entry_neg[hit]   = o.neg_total;
      entry_pos[hit]   = o.pos_total;
      evidence         = 18'(prior) + 18'(o.neg_total) + 18'(o.pos_total);
      o.malicious      = (o.pos_total < o.neg_total) && (evidence > 18'(threshold));
    end else if (entries < Depth) begin
      // new node: stored as reported, never judged on first sight
      o.inserted         = 1'b1;
      o.neg_total        = {8'd0, r.neg_increment};
      o.pos_total        = {8'd0, r.pos_increment};
      entry_ids[entries] = r.node_id;
      entry_neg[entries] = o.neg_total;
      entry_pos[entries] = o.pos_total;
      entries++;
    end else begin
      o.table_full = 1'b1;
    end
    return o;
  endfunction

  task automatic check_field(input string field, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      entries    = 0;
      threshold  = THRESHOLD_RESET;
      prior      = PRIOR_RESET;
      fail_count = 0;
      expected_outcomes.delete();
    end else begin
      // outcome transaction
      if (out_strobe) begin
        if (expected_outcomes.size() == 0) begin
          $display("%0t: outcome with no report pending, expected none actual %h",
                   $time, out_data);
          fail_count++;
        end else begin
          oldest = expected_outcomes.pop_front();
          check_field("was_known", 16'(oldest.was_known), 16'(out_data.was_known));
          check_field("inserted", 16'(oldest.inserted), 16'(out_data.inserted));
          check_field("table_full", 16'(oldest.table_full), 16'(out_data.table_full));
          check_field("neg_total", oldest.neg_total, out_data.neg_total);
          check_field("pos_total", oldest.pos_total, out_data.pos_total);
          check_field("malicious", 16'(oldest.malicious), 16'(out_data.malicious));
        end
      end
      // report transaction
      if (start && !busy) begin
        expected_outcomes.push_back(score_report(in_data));
      end
      // register writes, unknown indexes dropped
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_EVIDENCE_THRESHOLD: threshold = cfg_wdata;
          CFG_PRIOR_WEIGHT:       prior     = cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
    pending_reports = expected_outcomes.size();
  end

endmodule

[tb/node_trust_table_test.sv]
`timescale 1ns / 1ps

module node_trust_table_test;
  import ntt_pkg::*;

  // indexes past the register list, writes there must leave the rule alone
  localparam logic [CFG_IDX_W-1:0] CfgSpareLow  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CfgSpareHigh = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  in_t                   in_data   = '0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_EVIDENCE_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  busy;
  logic                  out_strobe;
  out_t                  out_data;
  int unsigned           fail_count;
  int unsigned           pending_reports;
  int unsigned           idle_pct = 0;

  always #10 clk = ~clk;

  node_trust_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  node_trust_table_check u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_data         (in_data),
    .out_strobe      (out_strobe),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending_reports (pending_reports)
  );

  // wait until no outcome is owed and the block is idle
  task automatic drain();
    while (pending_reports != 0 || busy) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // new trust rule, junk in the unused upper bits of the prior
  task automatic set_trust_rule(input logic [15:0] thr, input logic [7:0] pw);
    drain();
    write_reg(CFG_EVIDENCE_THRESHOLD, thr);
    write_reg(CFG_PRIOR_WEIGHT, {8'($urandom), pw});
  endtask

  // one report transaction, with random idle cycles ahead of it
  task automatic send_report(input in_t r);
    while ($urandom_range(99) < idle_pct) begin
      start   = 1'b0;
      in_data = in_t'(24'($urandom));
      @(negedge clk);
    end
    start   = 1'b1;
    in_data = r;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start   = 1'b0;
  endtask

  initial begin
    #50_000_000;
    $display("node_trust_table: mismatch");
    $finish;
  end

  initial begin
    logic [7:0]  sweep_ids [256];
    logic [7:0]  swap_id;
    logic [7:0]  id;
    int unsigned j;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset rule (threshold 10, prior 1)
    send_report(in_t'{8'd0, 8'd0, 8'd0});        // id zero is an ordinary key
    send_report(in_t'{8'd0, 8'd255, 8'd0});      // known, clearly malicious
    send_report(in_t'{8'd255, 8'd255, 8'd255});
    send_report(in_t'{8'd255, 8'd0, 8'd0});      // equal totals, not malicious
    send_report(in_t'{8'd1, 8'd5, 8'd4});
    send_report(in_t'{8'd1, 8'd0, 8'd0});        // evidence exactly at threshold
    send_report(in_t'{8'd1, 8'd1, 8'd0});        // one above threshold
    send_report(in_t'{8'hAA, 8'h55, 8'hAA});
    send_report(in_t'{8'h55, 8'hAA, 8'h55});
    send_report(in_t'{8'h55, 8'hAA, 8'h00});

    // zero threshold and prior: one negative is enough
    set_trust_rule(16'd0, 8'd0);
    send_report(in_t'{8'd2, 8'd1, 8'd0});
    send_report(in_t'{8'd2, 8'd0, 8'd0});
    send_report(in_t'{8'd2, 8'd0, 8'd1});

    // top threshold and prior, then writes to unused indexes
    set_trust_rule(16'hFFFF, 8'hFF);
    send_report(in_t'{8'd0, 8'd255, 8'd0});
    drain();
    write_reg(CfgSpareLow, 16'h0000);
    write_reg(CfgSpareHigh, 16'hFFFF);
    send_report(in_t'{8'd0, 8'd0, 8'd0});

    // small pool of nodes, back to back, one full pause midway
    set_trust_rule(16'($urandom_range(600)), 8'($urandom_range(255)));
    idle_pct = 0;
    for (int unsigned k = 0; k < 150; k++) begin
      if (k == 75) drain();
      send_report(in_t'{8'($urandom_range(7)), 8'($urandom), 8'($urandom)});
    end

    // two nodes hammered until their totals saturate
    set_trust_rule(16'hFFFF, 8'hFF);
    idle_pct = 78;
    for (int unsigned k = 0; k < 560; k++) begin
      if (k[0])
        send_report(in_t'{8'd4, 8'($urandom_range(127)), 8'($urandom_range(255, 240))});
      else
        send_report(in_t'{8'd3, 8'($urandom_range(255, 240)), 8'($urandom_range(127))});
    end

    // random nodes over the whole key range, more of the table in use
    set_trust_rule(16'd0, 8'd0);
    idle_pct = 34;
    for (int unsigned k = 0; k < 300; k++) begin
      send_report(in_t'{8'($urandom), 8'($urandom), 8'($urandom)});
    end

    // every key once in shuffled order: all entries in use afterwards
    for (int unsigned k = 0; k < 256; k++) sweep_ids[k] = 8'(k);
    for (int unsigned k = 255; k > 0; k--) begin
      j            = $urandom_range(k);
      swap_id      = sweep_ids[k];
      sweep_ids[k] = sweep_ids[j];
      sweep_ids[j] = swap_id;
    end
    set_trust_rule(16'($urandom), 8'($urandom));
    idle_pct = 78;
    for (int unsigned k = 0; k < 256; k++) begin
      send_report(in_t'{sweep_ids[k], 8'($urandom), 8'($urandom)});
    end

    // full table, hits anywhere in the scan
    set_trust_rule(16'hFFFF, 8'd0);
    write_reg(CfgSpareHigh, 16'($urandom));
    idle_pct = 34;
    for (int unsigned k = 0; k < 80; k++) begin
      id = 8'($urandom);
      send_report(in_t'{id, 8'($urandom), 8'($urandom)});
    end

    start = 1'b0;
    drain();
    repeat (300) @(negedge clk);
    if (fail_count == 0 && pending_reports == 0)
      $display("node_trust_table: match");
    else
      $display("node_trust_table: mismatch");
    $finish;
  end

endmodule
